// ----- rtl/rtq_pkg.sv -----
// ----------------------------------------------------------------------------
// rtq_pkg: shared constants and types for the axes-to-quaternion pipeline
// Internal matrix entries are signed Q1.30; widths below derive from that.
// ----------------------------------------------------------------------------
package rtq_pkg;

  localparam int IN_WIDTH_DEF = 16;
  localparam int OUT_FRAC_DEF = 14;

  localparam int MFRAC       = 30;            // fraction bits of matrix entries
  localparam int MW          = MFRAC + 2;     // signed Q1.30 entry width
  localparam int RATIO_STEPS = 2 * MFRAC;     // bits of sq/l2 quotient
  localparam int NSQ_BITS    = MFRAC + 1;     // bits of sqrt of that quotient
  localparam int NORM_LAT    = RATIO_STEPS + NSQ_BITS + 3;

  // output slot of a quaternion component
  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  // one normalized column vector
  typedef struct packed {
    logic                 zero;
    logic signed [MW-1:0] nz;
    logic signed [MW-1:0] ny;
    logic signed [MW-1:0] nx;
  } norm_t;

endpackage

// ----- rtl/rtq_sqrt.sv -----
// ----------------------------------------------------------------------------
// rtq_sqrt: pipelined integer square root
// floor(sqrt(x)), one result bit per register stage, N stages deep.
// ----------------------------------------------------------------------------
module rtq_sqrt #(
  parameter int N = rtq_pkg::NSQ_BITS
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] x,
  output logic [N-1:0]   root
);

  logic [N+1:0]   rrem   [1:N-1];
  logic [N-1:0]   rq     [1:N];
  logic [2*N-1:0] rx     [1:N-1];

  logic [N+1:0]   in_rem [0:N-1];
  logic [N-1:0]   in_q   [0:N-1];
  logic [2*N-1:0] in_x   [0:N-1];
  logic [N+1:0]   cur    [0:N-1];
  logic [N+1:0]   trial  [0:N-1];
  logic           take   [0:N-1];

  always_comb begin
    in_rem[0] = '0;
    in_q[0]   = '0;
    in_x[0]   = x;
    for (int j = 1; j < N; j++) begin
      in_rem[j] = rrem[j];
      in_q[j]   = rq[j];
      in_x[j]   = rx[j];
    end
    for (int j = 0; j < N; j++) begin
      // remainder stays below 2^N before the last step
      cur[j]   = {in_rem[j][N-1:0], in_x[j][2*N-1 -: 2]};
      trial[j] = {in_q[j], 2'b01};
      take[j]  = (cur[j] >= trial[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        rq[j+1] <= {in_q[j][N-2:0], take[j]};
      end
      for (int j = 0; j < N - 1; j++) begin
        rrem[j+1] <= take[j] ? (cur[j] - trial[j]) : cur[j];
        rx[j+1]   <= in_x[j] << 2;
      end
    end
  end

  assign root = rq[N];

endmodule

// ----- rtl/rtq_norm.sv -----
// ----------------------------------------------------------------------------
// rtq_norm: normalizes one axis vector to unit length in Q1.30
// Squares, length sum, bit-serial quotient sq/l2 and a square root, pipelined.
// ----------------------------------------------------------------------------
module rtq_norm #(
  parameter int IN_WIDTH = rtq_pkg::IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [IN_WIDTH-1:0] vx,
  input  logic signed [IN_WIDTH-1:0] vy,
  input  logic signed [IN_WIDTH-1:0] vz,
  output rtq_pkg::norm_t             nrm
);

  localparam int LW = 2 * IN_WIDTH;
  localparam int RS = rtq_pkg::RATIO_STEPS;
  localparam int NS = rtq_pkg::NSQ_BITS;
  localparam int MW = rtq_pkg::MW;

  logic signed [IN_WIDTH-1:0] v     [3];
  logic [IN_WIDTH-1:0]        mag   [3];
  logic [LW-1:0]              sq1   [3];
  logic [2:0]                 neg1;
  logic [LW-1:0]              l2_sum;

  logic [LW-1:0]              rrem  [0:RS-1][3];
  logic [LW-1:0]              rden  [0:RS-1];
  logic [RS-1:0]              rq    [0:RS][3];
  logic [2:0]                 rfull [0:RS];
  logic [2:0]                 rneg  [0:RS+NS];
  logic                       rzero [0:RS+NS];
  logic [LW:0]                rtwo  [0:RS-1][3];
  logic                       rtake [0:RS-1][3];
  logic [2*NS-1:0]            sx    [3];
  logic [NS-1:0]              root  [3];

  assign v[0] = vx;
  assign v[1] = vy;
  assign v[2] = vz;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = v[c][IN_WIDTH-1] ? IN_WIDTH'(-v[c]) : IN_WIDTH'(v[c]);
    end
    l2_sum = sq1[0] + sq1[1] + sq1[2];
    for (int j = 0; j < RS; j++) begin
      for (int c = 0; c < 3; c++) begin
        rtwo[j][c]  = {rrem[j][c], 1'b0};
        rtake[j][c] = (rtwo[j][c] >= {1'b0, rden[j]});
      end
    end
    // a component holding the whole length gives exactly 1.0
    for (int c = 0; c < 3; c++) begin
      sx[c] = rfull[RS][c] ? {2'b01, {RS{1'b0}}} : {2'b00, rq[RS][c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq1[c]  <= LW'(mag[c]) * LW'(mag[c]);
        neg1[c] <= v[c][IN_WIDTH-1];
      end

      rden[0]  <= l2_sum;
      rzero[0] <= (l2_sum == '0);
      rneg[0]  <= neg1;
      for (int c = 0; c < 3; c++) begin
        rrem[0][c]  <= sq1[c];
        rq[0][c]    <= '0;
        rfull[0][c] <= (sq1[c] >= l2_sum);
      end

      // restoring division, one quotient bit per stage
      for (int j = 1; j <= RS; j++) begin
        rfull[j] <= rfull[j-1];
        for (int c = 0; c < 3; c++) begin
          rq[j][c] <= {rq[j-1][c][RS-2:0], rtake[j-1][c]};
        end
      end
      for (int j = 1; j < RS; j++) begin
        rden[j] <= rden[j-1];
        for (int c = 0; c < 3; c++) begin
          rrem[j][c] <= rtake[j-1][c] ? LW'(rtwo[j-1][c] - {1'b0, rden[j-1]})
                                      : LW'(rtwo[j-1][c]);
        end
      end

      for (int j = 1; j <= RS + NS; j++) begin
        rneg[j]  <= rneg[j-1];
        rzero[j] <= rzero[j-1];
      end

      nrm.zero <= rzero[RS+NS];
      nrm.nx   <= rzero[RS+NS] ? '0 : (rneg[RS+NS][0] ? -MW'(root[0]) : MW'(root[0]));
      nrm.ny   <= rzero[RS+NS] ? '0 : (rneg[RS+NS][1] ? -MW'(root[1]) : MW'(root[1]));
      nrm.nz   <= rzero[RS+NS] ? '0 : (rneg[RS+NS][2] ? -MW'(root[2]) : MW'(root[2]));
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_root
    rtq_sqrt #(
      .N (NS)
    ) u_sqrt (
      .clk  (clk),
      .en   (en),
      .x    (sx[c]),
      .root (root[c])
    );
  end

endmodule

// ----- rtl/rotation_axes_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// rotation_axes_to_quaternion_unit: rotation matrix columns to unit quaternion
//
//   channel | dir | tdata (low bit up)                         | tuser
//   s_      | in  | xaxis_x..z, yaxis_x..z, zaxis_x..z (Q2.13)  | -
//   m_      | out | quat_w, quat_x, quat_y, quat_z (Q1.14)     | zero_axis
//
// One word per cycle in and out while the output is not stalled. The pipeline
// depth is set by the bit-per-stage quotient and square root units of the
// normalizers, the root unit and the output dividers. A stalled output
// freezes the whole pipeline; nothing is dropped. Reset clears the valid
// bits only.
// ----------------------------------------------------------------------------
module rotation_axes_to_quaternion_unit #(
  parameter int IN_WIDTH      = rtq_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = rtq_pkg::OUT_FRAC_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z, zaxis_x, zaxis_y, zaxis_z
  input  logic [((9*IN_WIDTH+7)/8)*8-1:0]               s_tdata,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [((4*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]      m_tdata,
  // zero_axis
  output logic [0:0]                                    m_tuser
);

  localparam int F     = OUT_FRAC_BITS;
  localparam int OW    = F + 2;
  localparam int QW    = OW;
  localparam int MW    = rtq_pkg::MW;
  localparam int MFRAC = rtq_pkg::MFRAC;
  localparam int DW    = MW + 1;
  localparam int AW    = MW + 1;
  localparam int BW    = MW + 1;
  localparam int NUMW  = MW + F;
  localparam int MDW   = ((4*OW+7)/8)*8;
  localparam int LAT   = rtq_pkg::NORM_LAT + MW + QW + 4;
  localparam logic signed [MW+2:0] ONE_A = (MW+3)'(1) << MFRAC;

  logic           en;
  logic           accept;
  logic [LAT-1:0] vld;

  rtq_pkg::norm_t nrm [3];

  // matrix and pivot stage
  logic signed [MW-1:0] nm     [3][3];
  logic signed [MW-1:0] mm     [3][3];
  rtq_pkg::slot_t       piv_c;
  rtq_pkg::slot_t       piv1;
  logic signed [MW:0]   trace1;
  logic                 zero1;

  // root argument and differences
  logic signed [MW+2:0] asum;
  logic signed [DW-1:0] dv     [4];
  rtq_pkg::slot_t       slot_c;
  logic [AW-1:0]        a2;
  logic signed [DW-1:0] d2     [4];
  rtq_pkg::slot_t       slot2;
  logic                 zero2;

  logic [2*MW-1:0]      rx;
  logic [MW-1:0]        root;
  logic signed [DW-1:0] dd     [1:MW][4];
  rtq_pkg::slot_t       ds     [1:MW];
  logic                 dz     [1:MW];

  // output dividers
  logic [MW-1:0]        dmag   [4];
  logic [NUMW-1:0]      dnum   [4];
  logic [BW-1:0]        drem   [0:QW-1][4];
  logic [QW-1:0]        dlow   [0:QW-1][4];
  logic [QW-1:0]        dq     [0:QW][4];
  logic [BW-1:0]        dden   [0:QW-1];
  logic [3:0]           dsign  [0:QW];
  logic [OW-1:0]        dpiv   [0:QW];
  rtq_pkg::slot_t       dslot  [0:QW];
  logic                 dzero  [0:QW];
  logic [BW:0]          dtwo   [0:QW-1][4];
  logic                 dtake  [0:QW-1][4];
  logic [OW-1:0]        lv     [4];
  logic [MDW-1:0]       out_word;

  assign en       = ~vld[LAT-1] | m_tready;
  assign s_tready = en & ~rst;
  assign accept   = s_tvalid & s_tready;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_norm
    rtq_norm #(
      .IN_WIDTH (IN_WIDTH)
    ) u_norm (
      .clk (clk),
      .en  (en),
      .vx  ($signed(s_tdata[(3*c)*IN_WIDTH +: IN_WIDTH])),
      .vy  ($signed(s_tdata[(3*c+1)*IN_WIDTH +: IN_WIDTH])),
      .vz  ($signed(s_tdata[(3*c+2)*IN_WIDTH +: IN_WIDTH])),
      .nrm (nrm[c])
    );
  end

  // columns of the matrix are the axis vectors
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nm[0][c] = nrm[c].nx;
      nm[1][c] = nrm[c].ny;
      nm[2][c] = nrm[c].nz;
    end
    // ties keep the lower index
    piv_c = rtq_pkg::SLOT_X;
    if (nm[1][1] > nm[0][0]) begin
      piv_c = rtq_pkg::SLOT_Y;
    end
    if (nm[2][2] > ((piv_c == rtq_pkg::SLOT_Y) ? nm[1][1] : nm[0][0])) begin
      piv_c = rtq_pkg::SLOT_Z;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dv[l] = '0;
    end
    slot_c = rtq_pkg::SLOT_W;
    asum   = (MW+3)'(trace1) + ONE_A;
    if (trace1 > 0) begin
      dv[rtq_pkg::SLOT_X] = DW'(mm[2][1]) - DW'(mm[1][2]);
      dv[rtq_pkg::SLOT_Y] = DW'(mm[0][2]) - DW'(mm[2][0]);
      dv[rtq_pkg::SLOT_Z] = DW'(mm[1][0]) - DW'(mm[0][1]);
    end else begin
      slot_c = piv1;
      case (piv1)
        rtq_pkg::SLOT_Y: begin
          asum = (MW+3)'(mm[1][1]) - (MW+3)'(mm[2][2]) - (MW+3)'(mm[0][0]) + ONE_A;
          dv[rtq_pkg::SLOT_W] = DW'(mm[0][2]) - DW'(mm[2][0]);
          dv[rtq_pkg::SLOT_Z] = DW'(mm[2][1]) + DW'(mm[1][2]);
          dv[rtq_pkg::SLOT_X] = DW'(mm[0][1]) + DW'(mm[1][0]);
        end
        rtq_pkg::SLOT_Z: begin
          asum = (MW+3)'(mm[2][2]) - (MW+3)'(mm[0][0]) - (MW+3)'(mm[1][1]) + ONE_A;
          dv[rtq_pkg::SLOT_W] = DW'(mm[1][0]) - DW'(mm[0][1]);
          dv[rtq_pkg::SLOT_X] = DW'(mm[0][2]) + DW'(mm[2][0]);
          dv[rtq_pkg::SLOT_Y] = DW'(mm[1][2]) + DW'(mm[2][1]);
        end
        default: begin
          slot_c = rtq_pkg::SLOT_X;
          asum = (MW+3)'(mm[0][0]) - (MW+3)'(mm[1][1]) - (MW+3)'(mm[2][2]) + ONE_A;
          dv[rtq_pkg::SLOT_W] = DW'(mm[2][1]) - DW'(mm[1][2]);
          dv[rtq_pkg::SLOT_Y] = DW'(mm[1][0]) + DW'(mm[0][1]);
          dv[rtq_pkg::SLOT_Z] = DW'(mm[2][0]) + DW'(mm[0][2]);
        end
      endcase
    end
  end

  assign rx = {1'b0, a2, {MFRAC{1'b0}}};

  rtq_sqrt #(
    .N (MW)
  ) u_root (
    .clk  (clk),
    .en   (en),
    .x    (rx),
    .root (root)
  );

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dmag[l] = MW'(dd[MW][l][DW-1] ? -dd[MW][l] : dd[MW][l]);
      // rounding: add half the divisor, which is the root itself
      dnum[l] = (NUMW'(dmag[l]) << F) + NUMW'(root);
    end
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < 4; l++) begin
        dtwo[j][l]  = {drem[j][l], dlow[j][l][QW-1]};
        dtake[j][l] = (dtwo[j][l] >= {1'b0, dden[j]});
      end
    end
    out_word = '0;
    for (int l = 0; l < 4; l++) begin
      lv[l] = dsign[QW][l] ? OW'(-dq[QW][l]) : dq[QW][l];
      if (dslot[QW] == rtq_pkg::slot_t'(l)) begin
        lv[l] = dpiv[QW];
      end
      out_word[l*OW +: OW] = lv[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm     <= nm;
      piv1   <= piv_c;
      trace1 <= (MW+1)'(nm[0][0]) + (MW+1)'(nm[1][1]) + (MW+1)'(nm[2][2]);
      zero1  <= nrm[0].zero | nrm[1].zero | nrm[2].zero;

      a2    <= AW'(asum);
      d2    <= dv;
      slot2 <= slot_c;
      zero2 <= zero1;

      // hold the differences while the root is worked out
      dd[1] <= d2;
      ds[1] <= slot2;
      dz[1] <= zero2;
      for (int j = 2; j <= MW; j++) begin
        dd[j] <= dd[j-1];
        ds[j] <= ds[j-1];
        dz[j] <= dz[j-1];
      end

      for (int l = 0; l < 4; l++) begin
        drem[0][l]  <= BW'(dnum[l] >> QW);
        dlow[0][l]  <= dnum[l][QW-1:0];
        dq[0][l]    <= '0;
        dsign[0][l] <= dd[MW][l][DW-1];
      end
      dden[0]  <= {root, 1'b0};
      dpiv[0]  <= OW'((root + (MW'(1) << (MFRAC - F))) >> (MFRAC + 1 - F));
      dslot[0] <= ds[MW];
      dzero[0] <= dz[MW];

      for (int j = 1; j <= QW; j++) begin
        dsign[j] <= dsign[j-1];
        dpiv[j]  <= dpiv[j-1];
        dslot[j] <= dslot[j-1];
        dzero[j] <= dzero[j-1];
        for (int l = 0; l < 4; l++) begin
          dq[j][l] <= {dq[j-1][l][QW-2:0], dtake[j-1][l]};
        end
      end
      for (int j = 1; j < QW; j++) begin
        dden[j] <= dden[j-1];
        for (int l = 0; l < 4; l++) begin
          drem[j][l] <= dtake[j-1][l] ? BW'(dtwo[j-1][l] - {1'b0, dden[j-1]})
                                      : BW'(dtwo[j-1][l]);
          dlow[j][l] <= dlow[j-1][l] << 1;
        end
      end

      m_tdata    <= out_word;
      m_tuser[0] <= dzero[QW];
    end
  end

endmodule

// ----- rtl/rtq_check.sv -----
// ----------------------------------------------------------------------------
// rtq_check: port-level checks for rotation_axes_to_quaternion_unit
// Watches the output handshake, input ready, reset and the range of quat_w.
// ----------------------------------------------------------------------------
module rtq_check #(
  parameter int OUT_FRAC_BITS = rtq_pkg::OUT_FRAC_DEF
) (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     s_tready,
  input logic                                     m_tvalid,
  input logic                                     m_tready,
  input logic [((4*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

  localparam int OW = OUT_FRAC_BITS + 2;
  localparam logic signed [OW-1:0] QMAX = OW'(1) << OUT_FRAC_BITS;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_w_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[OW-1:0]) <= QMAX) &&
                 ($signed(m_tdata[OW-1:0]) >= -QMAX))
    else $error("quat_w out of range");

endmodule

bind rotation_axes_to_quaternion_unit rtq_check #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_rtq_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
